/* hw/rtl/mmcs_pkg.sv */
package mmcs_pkg;

	// number of channel lanes carried through the design
	localparam int MAX_CH = 3;
	// result width per channel
	localparam int OUT_W = 8;
	// quotient bits produced by the serial divider
	localparam int QUOT_BITS = 8;
	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam logic [OUT_W-1:0] OUT_FULL_SCALE = 8'd255;
	localparam logic [OUT_W-1:0] OUT_ZERO = 8'd0;

	// how one channel of a map item is finished
	typedef enum logic [1:0] {
		LANE_ZERO,
		LANE_FLAT,
		LANE_SAT,
		LANE_DIV
	} lane_code_t;

	localparam int CODE_W = $bits(lane_code_t);

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CALC,
		BK_WAIT
	} back_state_t;

endpackage

/* hw/rtl/mmcs_queue.sv */
module mmcs_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	import mmcs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/mmcs_front.sv */
module mmcs_front #(
	parameter int SW = 16,
	parameter int CH = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 kind,
	input  logic                 first,
	input  logic signed [SW-1:0] sample [mmcs_pkg::MAX_CH],
	output logic                 q_push,
	output logic [2*mmcs_pkg::MAX_CH*SW+mmcs_pkg::MAX_CH*mmcs_pkg::CODE_W-1:0] q_data
);
	import mmcs_pkg::*;

	logic signed [SW-1:0] min_q [MAX_CH];
	logic signed [SW-1:0] max_q [MAX_CH];
	logic signed [SW:0]   diff  [MAX_CH];
	logic signed [SW:0]   range [MAX_CH];
	lane_code_t           code  [MAX_CH];

	// scan items update the extremes; first reloads them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_CH; c++) begin
				min_q[c] <= '0;
				max_q[c] <= '0;
			end
		end else if (accept && !kind) begin
			for (int c = 0; c < MAX_CH; c++) begin
				if (c < CH) begin
					if (first) begin
						min_q[c] <= sample[c];
						max_q[c] <= sample[c];
					end else begin
						if (sample[c] < min_q[c]) begin
							min_q[c] <= sample[c];
						end
						if (sample[c] > max_q[c]) begin
							max_q[c] <= sample[c];
						end
					end
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < MAX_CH; c++) begin
			diff[c]  = {sample[c][SW-1], sample[c]} - {min_q[c][SW-1], min_q[c]};
			range[c] = {max_q[c][SW-1], max_q[c]} - {min_q[c][SW-1], min_q[c]};
			if (c >= CH) begin
				code[c] = LANE_ZERO;
			end else if (range[c] == '0) begin
				code[c] = LANE_FLAT;
			end else if (range[c][SW] || diff[c][SW] || diff[c] == '0) begin
				code[c] = LANE_ZERO;
			end else if (diff[c] >= range[c]) begin
				// x at or above max: quotient is at least full scale
				code[c] = LANE_SAT;
			end else begin
				code[c] = LANE_DIV;
			end
			q_data[c*SW +: SW]                       = diff[c][SW-1:0];
			q_data[MAX_CH*SW + c*SW +: SW]           = range[c][SW-1:0];
			q_data[2*MAX_CH*SW + c*CODE_W +: CODE_W] = code[c];
		end
	end

	assign q_push = accept && kind;

endmodule

/* hw/rtl/mmcs_back.sv */
module mmcs_back #(
	parameter int SW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  logic [2*mmcs_pkg::MAX_CH*SW+mmcs_pkg::MAX_CH*mmcs_pkg::CODE_W-1:0] q_data,
	output logic q_pop,
	output logic [mmcs_pkg::OUT_W-1:0] res [mmcs_pkg::MAX_CH],
	output logic [mmcs_pkg::MAX_CH-1:0] res_flags,
	output logic res_valid,
	input  logic res_take
);
	import mmcs_pkg::*;

	localparam int NUM_W = SW + QUOT_BITS;
	localparam int K_W   = $clog2(QUOT_BITS);

	back_state_t      state_q;
	back_state_t      state_d;
	logic [NUM_W-1:0] rem_q  [MAX_CH];
	logic [NUM_W-1:0] dsh_q  [MAX_CH];
	logic [OUT_W-1:0] quo_q  [MAX_CH];
	lane_code_t       code_q [MAX_CH];
	logic [K_W-1:0]   k_q;
	logic             out_free;
	logic             load;
	logic             step;
	logic             store;
	logic [SW-1:0]    in_diff [MAX_CH];
	logic [SW-1:0]    in_rng  [MAX_CH];
	lane_code_t       in_code [MAX_CH];

	always_comb begin
		for (int c = 0; c < MAX_CH; c++) begin
			in_diff[c] = q_data[c*SW +: SW];
			in_rng[c]  = q_data[MAX_CH*SW + c*SW +: SW];
			in_code[c] = lane_code_t'(q_data[2*MAX_CH*SW + c*CODE_W +: CODE_W]);
		end
	end

	assign out_free = !res_valid || res_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		step    = 1'b0;
		store   = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					load    = 1'b1;
					state_d = BK_CALC;
				end
			end
			BK_CALC: begin
				step = 1'b1;
				if (k_q == '0) begin
					state_d = BK_WAIT;
				end
			end
			BK_WAIT: begin
				if (out_free) begin
					store   = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign q_pop = load;

	// restoring division of 255*diff by range, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (load) begin
			k_q <= K_W'(QUOT_BITS - 1);
			for (int c = 0; c < MAX_CH; c++) begin
				code_q[c] <= in_code[c];
				rem_q[c]  <= {in_diff[c], {QUOT_BITS{1'b0}}} - NUM_W'(in_diff[c]);
				dsh_q[c]  <= {1'b0, in_rng[c], {(QUOT_BITS-1){1'b0}}};
				quo_q[c]  <= (in_code[c] == LANE_SAT) ? OUT_FULL_SCALE : OUT_ZERO;
			end
		end else if (step) begin
			k_q <= k_q - 1'b1;
			for (int c = 0; c < MAX_CH; c++) begin
				if (code_q[c] == LANE_DIV) begin
					if (rem_q[c] >= dsh_q[c]) begin
						rem_q[c] <= rem_q[c] - dsh_q[c];
						quo_q[c] <= {quo_q[c][OUT_W-2:0], 1'b1};
					end else begin
						quo_q[c] <= {quo_q[c][OUT_W-2:0], 1'b0};
					end
					dsh_q[c] <= dsh_q[c] >> 1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store) begin
			for (int c = 0; c < MAX_CH; c++) begin
				res[c]       <= quo_q[c];
				res_flags[c] <= (code_q[c] == LANE_FLAT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (store) begin
			res_valid <= 1'b1;
		end else if (res_take) begin
			res_valid <= 1'b0;
		end
	end

endmodule

/* hw/rtl/min_max_contrast_stretch_core.sv */
// channel  | direction | handshake          | payload
// input    | in        | push / full        | kind, first, sample_b, sample_g, sample_r
// result   | out       | pop / empty        | out_b, out_g, out_r, flat_flags
//
// A scan item is absorbed in the cycle it is accepted. A map item is queued and
// then passes through the back end in order: a load, the shared-step restoring
// divider (three lanes side by side) and a write of the result register.
// Reset clears the extremes to zero and empties the queue and result register.
// full rises only while the two-entry queue is full; a result that is not
// popped holds the divider, and the queue keeps taking items meanwhile.
module min_max_contrast_stretch_core #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int CHANNELS = 3
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic                           kind,
	input  logic                           first,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_b,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_g,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_r,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     out_b,
	output logic [7:0]                     out_g,
	output logic [7:0]                     out_r,
	output logic [2:0]                     flat_flags
);
	import mmcs_pkg::*;

	localparam int ENTRY_W = 2*MAX_CH*SAMPLE_WIDTH + MAX_CH*CODE_W;

	logic signed [SAMPLE_WIDTH-1:0] sample [MAX_CH];
	logic                           accept;
	logic                           q_push;
	logic [ENTRY_W-1:0]             q_wdata;
	logic [ENTRY_W-1:0]             q_rdata;
	logic                           q_full;
	logic                           q_empty;
	logic                           q_pop;
	logic [OUT_W-1:0]               res [MAX_CH];
	logic [MAX_CH-1:0]              res_flags;
	logic                           res_valid;

	assign sample[0] = sample_b;
	assign sample[1] = sample_g;
	assign sample[2] = sample_r;
	assign full      = q_full;
	assign accept    = push && !q_full;

	mmcs_front #(
		.SW(SAMPLE_WIDTH),
		.CH(CHANNELS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.kind   (kind),
		.first  (first),
		.sample (sample),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	mmcs_queue #(
		.W(ENTRY_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	mmcs_back #(
		.SW(SAMPLE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.res       (res),
		.res_flags (res_flags),
		.res_valid (res_valid),
		.res_take  (pop)
	);

	assign empty      = !res_valid;
	assign out_b      = res[0];
	assign out_g      = res[1];
	assign out_r      = res[2];
	assign flat_flags = res_flags;

endmodule

/* tb/tb_top.sv */
module tb_top;
	import mmcs_pkg::*;

	localparam int SW = 16;
	localparam int CHANNELS = 3;
	localparam int N_PHASES = 4;
	localparam int RANDOM_PER_PHASE = 358;

	typedef struct packed {
		logic [OUT_W-1:0] b;
		logic [OUT_W-1:0] g;
		logic [OUT_W-1:0] r;
		logic [2:0]       flags;
	} pixel_out_t;

	typedef struct packed {
		logic          kind;
		logic          first;
		logic [SW-1:0] b;
		logic [SW-1:0] g;
		logic [SW-1:0] r;
		logic          typed;
		pixel_out_t    want;
	} stim_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic                 kind;
	logic                 first;
	logic signed [SW-1:0] sample_b;
	logic signed [SW-1:0] sample_g;
	logic signed [SW-1:0] sample_r;
	logic                 empty;
	logic                 pop;
	logic [7:0]           out_b;
	logic [7:0]           out_g;
	logic [7:0]           out_r;
	logic [2:0]           flat_flags;

	// expected result of the item on the input ports, when typed in by hand
	logic       cur_typed;
	pixel_out_t cur_want;

	int lane_lo[MAX_CH];
	int lane_hi[MAX_CH];
	pixel_out_t pending_px[$];
	pixel_out_t exp_px;
	pixel_out_t got_px;

	int send_idle;
	int recv_stall;
	int fails;
	int n_scans;
	int n_maps;
	int n_flat;

	min_max_contrast_stretch_core #(
		.SAMPLE_WIDTH(SW),
		.CHANNELS(CHANNELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.first(first),
		.sample_b(sample_b),
		.sample_g(sample_g),
		.sample_r(sample_r),
		.empty(empty),
		.pop(pop),
		.out_b(out_b),
		.out_g(out_g),
		.out_r(out_r),
		.flat_flags(flat_flags)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [OUT_W-1:0] stretch_lane(input int x, input int lo, input int hi,
			output logic flat);
		int range;
		int diff;
		int q;
		range = hi - lo;
		diff = x - lo;
		flat = 1'b0;
		if (range == 0) begin
			flat = 1'b1;
			return OUT_ZERO;
		end
		if (range < 0 || diff <= 0)
			return OUT_ZERO;
		q = (255 * diff) / range;
		if (q > 255)
			q = 255;
		return q[OUT_W-1:0];
	endfunction

	function automatic pixel_out_t stretch_pixel(input logic [SW-1:0] b, input logic [SW-1:0] g,
			input logic [SW-1:0] r);
		int x[MAX_CH];
		logic [OUT_W-1:0] v[MAX_CH];
		logic flat;
		pixel_out_t px;
		x[0] = int'($signed(b));
		x[1] = int'($signed(g));
		x[2] = int'($signed(r));
		px.flags = '0;
		for (int c = 0; c < MAX_CH; c++) begin
			v[c] = OUT_ZERO;
			if (c < CHANNELS) begin
				v[c] = stretch_lane(x[c], lane_lo[c], lane_hi[c], flat);
				px.flags[c] = flat;
			end
		end
		px.b = v[0];
		px.g = v[1];
		px.r = v[2];
		return px;
	endfunction

	task automatic track_extremes(input logic reload, input logic [SW-1:0] b,
			input logic [SW-1:0] g, input logic [SW-1:0] r);
		int x[MAX_CH];
		x[0] = int'($signed(b));
		x[1] = int'($signed(g));
		x[2] = int'($signed(r));
		for (int c = 0; c < MAX_CH && c < CHANNELS; c++) begin
			if (reload) begin
				lane_lo[c] = x[c];
				lane_hi[c] = x[c];
			end else begin
				if (x[c] < lane_lo[c])
					lane_lo[c] = x[c];
				if (x[c] > lane_hi[c])
					lane_hi[c] = x[c];
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				if (kind) begin
					pending_px.push_back(cur_typed ? cur_want
						: stretch_pixel(sample_b, sample_g, sample_r));
					n_maps++;
				end else begin
					track_extremes(first, sample_b, sample_g, sample_r);
					n_scans++;
				end
			end
			if (pop && !empty) begin
				got_px = '{out_b, out_g, out_r, flat_flags};
				if (pending_px.size() == 0) begin
					$error("result item with nothing expected: b=%0d g=%0d r=%0d flags=%0d",
						out_b, out_g, out_r, flat_flags);
					fails++;
				end else begin
					exp_px = pending_px.pop_front();
					if (exp_px.flags != 0)
						n_flat++;
					if (got_px.b !== exp_px.b) begin
						$error("out_b: expected %0d, got %0d", exp_px.b, got_px.b);
						fails++;
					end
					if (got_px.g !== exp_px.g) begin
						$error("out_g: expected %0d, got %0d", exp_px.g, got_px.g);
						fails++;
					end
					if (got_px.r !== exp_px.r) begin
						$error("out_r: expected %0d, got %0d", exp_px.r, got_px.r);
						fails++;
					end
					if (got_px.flags !== exp_px.flags) begin
						$error("flat_flags: expected %0d, got %0d", exp_px.flags,
							got_px.flags);
						fails++;
					end
				end
			end
		end
	end

	// result side: pop drops at random according to the current stall rate
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop = ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send(input stim_t s);
		while ($urandom_range(99) < send_idle) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		kind = s.kind;
		first = s.first;
		sample_b = s.b;
		sample_g = s.g;
		sample_r = s.r;
		cur_typed = s.typed;
		cur_want = s.want;
		do @(posedge clk); while (full);
		@(negedge clk);
	endtask

	function automatic stim_t row(input logic k, input logic f, input int b, input int g,
			input int r, input logic typed, input int eb, input int eg, input int er,
			input int ef);
		stim_t s;
		s.kind = k;
		s.first = f;
		s.b = b[SW-1:0];
		s.g = g[SW-1:0];
		s.r = r[SW-1:0];
		s.typed = typed;
		s.want.b = eb[OUT_W-1:0];
		s.want.g = eg[OUT_W-1:0];
		s.want.r = er[OUT_W-1:0];
		s.want.flags = ef[2:0];
		return s;
	endfunction

	function automatic int clamp16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int rand16();
		logic [SW-1:0] t;
		t = SW'($urandom);
		return int'($signed(t));
	endfunction

	function automatic int near(input int center, input int span);
		return clamp16(center + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic random_items(input int n_items);
		int sent;
		int mode;
		int span;
		int cnt;
		int ctr[MAX_CH];
		stim_t s;
		sent = 0;
		s = '0;
		while (sent < n_items) begin
			mode = $urandom_range(9);
			if (mode == 9) begin
				// noise: anything at all, including stray first bits on map items
				cnt = $urandom_range(1, 4);
				for (int k = 0; k < cnt; k++) begin
					s.kind = 1'($urandom_range(1));
					s.first = 1'($urandom_range(1));
					s.b = SW'($urandom);
					s.g = SW'($urandom);
					s.r = SW'($urandom);
					send(s);
				end
				sent += cnt;
			end else begin
				// one frame: scan items set the extremes, map items stretch within them
				if (mode < 3)
					span = 32767;
				else if (mode < 6)
					span = $urandom_range(0, 3);
				else
					span = $urandom_range(4, 2000);
				for (int c = 0; c < MAX_CH; c++)
					ctr[c] = rand16();
				cnt = $urandom_range(1, 6);
				for (int k = 0; k < cnt; k++) begin
					s.kind = 1'b0;
					// now and then a frame lacks its first item
					s.first = (k == 0) && ($urandom_range(7) != 0);
					s.b = SW'(near(ctr[0], span));
					s.g = SW'(near(ctr[1], span));
					s.r = SW'(near(ctr[2], span));
					send(s);
				end
				sent += cnt;
				cnt = $urandom_range(1, 6);
				for (int k = 0; k < cnt; k++) begin
					s.kind = 1'b1;
					s.first = 1'($urandom_range(1));
					if ($urandom_range(3) != 0) begin
						s.b = SW'(near(ctr[0], span + span / 4 + 2));
						s.g = SW'(near(ctr[1], span + span / 4 + 2));
						s.r = SW'(near(ctr[2], span + span / 4 + 2));
					end else begin
						s.b = SW'($urandom);
						s.g = SW'($urandom);
						s.r = SW'($urandom);
					end
					send(s);
				end
				sent += cnt;
			end
		end
	endtask

	initial begin
		stim_t directed[$];
		int idle_of_phase[N_PHASES];
		int stall_of_phase[N_PHASES];
		idle_of_phase = '{0, 85, 0, 31};
		stall_of_phase = '{0, 0, 85, 31};
		arst_n = 1'b0;
		push = 1'b0;
		kind = 1'b0;
		first = 1'b0;
		sample_b = '0;
		sample_g = '0;
		sample_r = '0;
		cur_typed = 1'b0;
		cur_want = '0;
		send_idle = 0;
		recv_stall = 0;
		fails = 0;
		n_scans = 0;
		n_maps = 0;
		n_flat = 0;
		for (int c = 0; c < MAX_CH; c++) begin
			lane_lo[c] = 0;
			lane_hi[c] = 0;
		end

		// map before any scan: every channel flat
		directed.push_back(row(1, 0, 0, 0, 0, 1, 0, 0, 0, 7));
		// scan with no first item since reset grows from zero
		directed.push_back(row(0, 0, 100, -100, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(1, 0, 50, -50, 0, 0, 0, 0, 0, 0));
		// first on a map item is ignored
		directed.push_back(row(1, 1, 100, 0, 5, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 1, -32768, -32768, 32767, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, 32767, -32768, -32768, 0, 0, 0, 0, 0));
		directed.push_back(row(1, 0, 32767, 0, -32768, 1, 255, 0, 0, 2));
		directed.push_back(row(1, 0, -32768, 32767, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 0, 1000, -1000, 1, 0, 0, 0, 0, 0));
		// below min saturates low, above max saturates high
		directed.push_back(row(1, 0, -5, 2000, 1, 1, 0, 255, 255, 0));
		directed.push_back(row(1, 0, 1000, -1000, 0, 1, 255, 0, 0, 0));
		directed.push_back(row(1, 0, 500, -500, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(0, 1, 32767, 32767, 32767, 0, 0, 0, 0, 0));
		directed.push_back(row(1, 0, -32768, -32768, 32767, 1, 0, 0, 0, 7));
		directed.push_back(row(0, 0, 32766, -1, 0, 0, 0, 0, 0, 0));
		directed.push_back(row(1, 0, 32767, 16383, 32766, 0, 0, 0, 0, 0));
		directed.push_back(row(1, 1, -1, -32768, -32768, 0, 0, 0, 0, 0));

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send(directed[i]);

		for (int p = 0; p < N_PHASES; p++) begin
			send_idle = idle_of_phase[p];
			recv_stall = stall_of_phase[p];
			random_items(RANDOM_PER_PHASE);
		end

		push = 1'b0;
		while (pending_px.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d scan items and %0d map items (%0d with a flat channel)",
			n_scans, n_maps, n_flat);
		$display("over four idle/stall mixes on both sides; %0d mismatches", fails);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/mmcs_pkg.sv
hw/rtl/mmcs_queue.sv
hw/rtl/mmcs_front.sv
hw/rtl/mmcs_back.sv
hw/rtl/min_max_contrast_stretch_core.sv
tb/tb_top.sv
